// ----- rtl/mtss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer package
// Shared widths, register indexes and the quarter-wave sine table entry
// function.
// ----------------------------------------------------------------------------
package mtss_pkg;

	localparam int unsigned STEP_W   = 32;
	localparam int unsigned OFFS_W   = 16;
	localparam int unsigned AMP_W    = 16;
	localparam int unsigned EN_W     = 2;
	localparam int unsigned INDEX_W  = 32;
	localparam int unsigned SAMPLE_W = 18;
	localparam int unsigned SIN_W    = 15;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned PHASE_BITS_DEF = 32;
	localparam int unsigned SINE_TABLE_ADDR_BITS_DEF = 10;

	localparam logic [CFG_IDX_W-1:0] REG_TONE0_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TONE0_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TONE0_AMP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TONE1_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TONE1_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TONE1_AMP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_ENABLE  = 3'd6;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SIN_MAX     = 64'd32767;

	// Entry k of the quarter-wave table: sin(pi/2 * (k + 1/2) / 2^addr_bits)
	// by a truncated Taylor series in Q30, rounded half up to Q1.15.
	function automatic logic [SIN_W-1:0] quarter_entry(input int unsigned k,
			input int unsigned addr_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] q;
		x    = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (addr_bits + 1);
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		term = ((term * x2) >> 30) / 64'd6;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd20;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd42;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd72;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd110;
		acc  = acc - term;
		q    = (acc + 64'd16384) >> 15;
		if (q > SIN_MAX) begin
			q = SIN_MAX;
		end
		return q[SIN_W-1:0];
	endfunction

endpackage

// ----- rtl/multi_tone_sine_synth_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer
// Evaluates the sum of up to two enabled sine tones at an absolute sample
// index, using a phase multiply, a quarter-wave sine table and amplitude
// scaling in a five-stage pipeline.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_stall, sample_index,          sink
//            last_in_block
//   out      out_valid, out_stall, sample_value,         source
//            last_out
//   cfg      cfg_wr_en, cfg_index, cfg_data             sink, write only
//
// One transaction is accepted per clock while in_stall is low.
// The rate is set by the pipeline: multiply, phase add, table read, amplitude
// multiply and tone sum each take one stage.
// Each stage holds its data when the next stage is full and cannot move, so
// empty stages keep filling while the output is stalled.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module multi_tone_sine_synth_top #(
	parameter int unsigned PHASE_BITS = mtss_pkg::PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_ADDR_BITS = mtss_pkg::SINE_TABLE_ADDR_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mtss_pkg::INDEX_W-1:0]         sample_index,
	input  logic                                 last_in_block,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mtss_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                 last_out,
	input  logic                                 cfg_wr_en,
	input  logic [mtss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mtss_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import mtss_pkg::*;

	localparam int unsigned A_W = SINE_TABLE_ADDR_BITS;
	localparam int unsigned TABLE_SIZE = 1 << SINE_TABLE_ADDR_BITS;
	localparam int unsigned WIDE_W = STEP_W + OFFS_W;

	typedef logic [SIN_W-1:0] sine_rom_t [TABLE_SIZE];

	function automatic sine_rom_t build_rom();
		sine_rom_t r;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			r[A_W'(k)] = quarter_entry(unsigned'(k), SINE_TABLE_ADDR_BITS);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	logic [STEP_W-1:0] tone0_step_q;
	logic [OFFS_W-1:0] tone0_offset_q;
	logic [AMP_W-1:0]  tone0_amp_q;
	logic [STEP_W-1:0] tone1_step_q;
	logic [OFFS_W-1:0] tone1_offset_q;
	logic [AMP_W-1:0]  tone1_amp_q;
	logic [EN_W-1:0]   tone_enable_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_1, adv_2, adv_3, adv_4, adv_5;

	logic [STEP_W-1:0]     p32_0_s1, p32_1_s1;
	logic                  last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [PHASE_BITS-1:0] phase0_s2, phase1_s2;
	logic [SIN_W-1:0]      mag0_s3, mag1_s3;
	logic                  neg0_s3, neg1_s3, neg0_s4, neg1_s4;
	logic [AMP_W-1:0]      prod0_s4, prod1_s4;
	logic signed [SAMPLE_W-1:0] sum_s5;

	logic [STEP_W-1:0] mul0, mul1;
	logic [WIDE_W-1:0] wide0, wide1;
	logic [1:0]        quad0, quad1;
	logic [A_W-1:0]    idx0, idx1, addr0, addr1;
	logic [31:0]       scaled0, scaled1;
	logic signed [SAMPLE_W-1:0] tone0_val, tone1_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone0_step_q   <= '0;
			tone0_offset_q <= '0;
			tone0_amp_q    <= '0;
			tone1_step_q   <= '0;
			tone1_offset_q <= '0;
			tone1_amp_q    <= '0;
			tone_enable_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TONE0_STEP:   tone0_step_q   <= cfg_data[STEP_W-1:0];
				REG_TONE0_OFFSET: tone0_offset_q <= cfg_data[OFFS_W-1:0];
				REG_TONE0_AMP:    tone0_amp_q    <= cfg_data[AMP_W-1:0];
				REG_TONE1_STEP:   tone1_step_q   <= cfg_data[STEP_W-1:0];
				REG_TONE1_OFFSET: tone1_offset_q <= cfg_data[OFFS_W-1:0];
				REG_TONE1_AMP:    tone1_amp_q    <= cfg_data[AMP_W-1:0];
				REG_TONE_ENABLE:  tone_enable_q  <= cfg_data[EN_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its contents move on.
	assign adv_5 = !valid_s5 || !out_stall;
	assign adv_4 = !valid_s4 || adv_5;
	assign adv_3 = !valid_s3 || adv_4;
	assign adv_2 = !valid_s2 || adv_3;
	assign adv_1 = !valid_s1 || adv_2;
	assign in_stall = !adv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_1) begin
				valid_s1 <= in_valid;
			end
			if (adv_2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_4) begin
				valid_s4 <= valid_s3;
			end
			if (adv_5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	assign mul0 = tone0_step_q * sample_index;
	assign mul1 = tone1_step_q * sample_index;

	always_ff @(posedge clk) begin
		if (adv_1 && in_valid) begin
			p32_0_s1 <= mul0;
			p32_1_s1 <= mul1;
			last_s1  <= last_in_block;
		end
	end

	assign wide0 = {p32_0_s1, {OFFS_W{1'b0}}} + {tone0_offset_q, {STEP_W{1'b0}}};
	assign wide1 = {p32_1_s1, {OFFS_W{1'b0}}} + {tone1_offset_q, {STEP_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv_2 && valid_s1) begin
			phase0_s2 <= wide0[WIDE_W-1 -: PHASE_BITS];
			phase1_s2 <= wide1[WIDE_W-1 -: PHASE_BITS];
			last_s2   <= last_s1;
		end
	end

	assign quad0 = phase0_s2[PHASE_BITS-1 -: 2];
	assign quad1 = phase1_s2[PHASE_BITS-1 -: 2];
	assign idx0  = phase0_s2[PHASE_BITS-3 -: A_W];
	assign idx1  = phase1_s2[PHASE_BITS-3 -: A_W];
	assign addr0 = quad0[0] ? ~idx0 : idx0;
	assign addr1 = quad1[0] ? ~idx1 : idx1;

	always_ff @(posedge clk) begin
		if (adv_3 && valid_s2) begin
			mag0_s3 <= SINE_ROM[addr0];
			mag1_s3 <= SINE_ROM[addr1];
			neg0_s3 <= quad0[1];
			neg1_s3 <= quad1[1];
			last_s3 <= last_s2;
		end
	end

	assign scaled0 = {16'b0, tone0_amp_q} * {17'b0, mag0_s3} + 32'd16384;
	assign scaled1 = {16'b0, tone1_amp_q} * {17'b0, mag1_s3} + 32'd16384;

	always_ff @(posedge clk) begin
		if (adv_4 && valid_s3) begin
			prod0_s4 <= scaled0[30:15];
			prod1_s4 <= scaled1[30:15];
			neg0_s4  <= neg0_s3;
			neg1_s4  <= neg1_s3;
			last_s4  <= last_s3;
		end
	end

	always_comb begin
		tone0_val = '0;
		tone1_val = '0;
		if (tone_enable_q[0]) begin
			tone0_val = neg0_s4 ? -$signed({2'b00, prod0_s4}) : $signed({2'b00, prod0_s4});
		end
		if (tone_enable_q[1]) begin
			tone1_val = neg1_s4 ? -$signed({2'b00, prod1_s4}) : $signed({2'b00, prod1_s4});
		end
	end

	always_ff @(posedge clk) begin
		if (adv_5 && valid_s4) begin
			sum_s5  <= tone0_val + tone1_val;
			last_s5 <= last_s4;
		end
	end

	assign out_valid    = valid_s5;
	assign sample_value = sum_s5;
	assign last_out     = last_s5;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("Accepted transaction did not reach the first stage.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall)
		else $error("Input stalled while the pipeline had an empty stage.");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_4 |=> valid_s3 && $stable(mag0_s3) && $stable(mag1_s3))
		else $error("Table read stage changed while blocked.");

endmodule
